// File: design/nps_pkg.sv
// Package for the nearest point search block: types, codes and widths.
// Depends on nothing; used by every design file.
`timescale 1ns / 1ps
package nps_pkg;
   localparam int LAT_W = 24;
   localparam int LON_W = 25;
   localparam int DIST_W = 25;
   localparam int CNT_W = 5;
   localparam int RANK_W = 4;
   localparam int MAX_OUT = 16;
   localparam int DSQ_W = 52;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 200;

   typedef enum logic [1:0] {
      KIND_STORED = 2'd0,
      KIND_FULL = 2'd1,
      KIND_NEIGHBOR = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_SQRT,
      ST_OUT
   } state_type;
endpackage

// File: design/nearest_point_search.sv
// Nearest point search top level: point store, scan sequencer, shared square root unit.
// Depends on nps_pkg.
`timescale 1ns / 1ps
// An insert is answered with one response. A search runs one pass over the
// stored points per returned neighbor: each stored point takes two passes
// through the shared squaring multiplier, the square root is then formed
// one bit a cycle, and the response is loaded. The next pass starts at once,
// but its response is not loaded until the previous one has been taken with
// rsp_tready. No request is taken while one is in progress or a response is
// pending.
module nearest_point_search #(
   parameter int CAPACITY = 16,
   parameter int ID_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // operation[0]
   input  logic req_tuser,
   // point_id[15:0], query_lat[39:16], query_lon[64:40]
   input  logic [nps_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic rsp_tlast,
   // kind[1:0]
   output nps_pkg::kind_type rsp_tuser,
   // found_id[15:0], found_lat[39:16], found_lon[64:40], distance[89:65],
   // rank[93:90], box_min_lon[118:94], box_min_lat[142:119],
   // box_max_lon[167:143], box_max_lat[191:168], entries[196:192]
   output logic [nps_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [4:0] csr_wr_data
);
   import nps_pkg::*;
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FC_W = $clog2(CAPACITY + 1);

   logic signed [LAT_W-1:0] mem_lat [CAPACITY];
   logic signed [LON_W-1:0] mem_lon [CAPACITY];
   logic [ID_BITS-1:0] mem_id [CAPACITY];

   state_type state_ff, state_in;
   logic [4:0] count_ff;
   logic [FC_W-1:0] fill_ff, fill_in;
   logic signed [LON_W-1:0] bminlo_ff, bminlo_in, bmaxlo_ff, bmaxlo_in;
   logic signed [LAT_W-1:0] bminla_ff, bminla_in, bmaxla_ff, bmaxla_in;
   logic signed [LAT_W-1:0] qlat_ff, qlat_in;
   logic signed [LON_W-1:0] qlon_ff, qlon_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] best_i_ff, best_i_in, prev_i_ff, prev_i_in;
   logic [DSQ_W-1:0] best_d_ff, best_d_in, prev_d_ff, prev_d_in;
   logic have_ff, have_in;
   logic [RANK_W:0] rank_ff, rank_in;
   logic [RANK_W:0] want_ff, want_in;
   logic [DSQ_W-1:0] sq_ff, sq_in;
   logic [DSQ_W-1:0] rem_ff, rem_in;
   logic [DSQ_W-1:0] root_ff, root_in;
   logic [4:0] step_ff, step_in;
   logic ins_ff, ins_in;
   logic ovalid_ff, ovalid_in, olast_ff, olast_in;
   kind_type okind_ff, okind_in;
   logic [RSP_TDATA_W-1:0] odata_ff, odata_in;
   logic wr_en;

   logic req_op;
   logic [ID_BITS-1:0] req_id;
   logic signed [LAT_W-1:0] req_lat;
   logic signed [LON_W-1:0] req_lon;
   assign req_op = req_tuser;
   assign req_id = req_tdata[ID_BITS-1:0];
   assign req_lat = req_tdata[39:16];
   assign req_lon = req_tdata[64:40];

   // shared unit operands
   logic signed [LAT_W:0] dla;
   logic signed [LON_W:0] dlo;
   logic [LON_W:0] abs_v;
   logic [2*LON_W+1:0] prod;
   logic [DSQ_W-1:0] trial;
   logic [DSQ_W-1:0] cand_d;
   logic sel_lat;
   assign dla = LAT_W'(0) + (LAT_W+1)'(mem_lat[idx_ff]) - (LAT_W+1)'(qlat_ff);
   assign dlo = (LON_W+1)'(mem_lon[idx_ff]) - (LON_W+1)'(qlon_ff);
   always_comb begin
      if (sel_lat) begin
         abs_v = dla[LAT_W] ? (LON_W+1)'(-dla) : (LON_W+1)'(dla);
      end else begin
         abs_v = dlo[LON_W] ? (LON_W+1)'(-dlo) : (LON_W+1)'(dlo);
      end
   end
   assign prod = abs_v * abs_v;
   assign cand_d = sq_ff + DSQ_W'(prod);
   assign sel_lat = (step_ff == 5'd0);

   logic [DSQ_W-1:0] sbit;
   assign sbit = DSQ_W'(1) << (2 * (5'd25 - step_ff));
   assign trial = root_ff + sbit;

   function automatic logic [RSP_TDATA_W-1:0] pack(
      input logic [15:0] id, input logic [LAT_W-1:0] la,
      input logic [LON_W-1:0] lo, input logic [DIST_W-1:0] d,
      input logic [RANK_W-1:0] r, input logic [LON_W-1:0] a,
      input logic [LAT_W-1:0] b, input logic [LON_W-1:0] c,
      input logic [LAT_W-1:0] e, input logic [4:0] n);
      pack = {3'b000, n, e, c, b, a, r, d, lo, la, id};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 5'd2;
         fill_ff <= '0;
         bminlo_ff <= '0; bmaxlo_ff <= '0; bminla_ff <= '0; bmaxla_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         fill_ff <= fill_in;
         bminlo_ff <= bminlo_in; bmaxlo_ff <= bmaxlo_in;
         bminla_ff <= bminla_in; bmaxla_ff <= bmaxla_in;
         ovalid_ff <= ovalid_in;
      end
      qlat_ff <= qlat_in; qlon_ff <= qlon_in; idx_ff <= idx_in;
      best_i_ff <= best_i_in; prev_i_ff <= prev_i_in;
      best_d_ff <= best_d_in; prev_d_ff <= prev_d_in; have_ff <= have_in;
      rank_ff <= rank_in; want_ff <= want_in; sq_ff <= sq_in;
      rem_ff <= rem_in; root_ff <= root_in; step_ff <= step_in; ins_ff <= ins_in;
      olast_ff <= olast_in; okind_ff <= okind_in; odata_ff <= odata_in;
      if (wr_en) begin
         mem_lat[fill_ff[IDX_W-1:0]] <= req_lat;
         mem_lon[fill_ff[IDX_W-1:0]] <= req_lon;
         mem_id[fill_ff[IDX_W-1:0]] <= req_id;
      end
   end

   logic [15:0] oid;
   assign oid = 16'(mem_id[best_i_ff]);

   always_comb begin
      logic skip;
      logic [4:0] w;
      state_in = state_ff;
      fill_in = fill_ff;
      bminlo_in = bminlo_ff; bmaxlo_in = bmaxlo_ff;
      bminla_in = bminla_ff; bmaxla_in = bmaxla_ff;
      qlat_in = qlat_ff; qlon_in = qlon_ff; idx_in = idx_ff;
      best_i_in = best_i_ff; prev_i_in = prev_i_ff;
      best_d_in = best_d_ff; prev_d_in = prev_d_ff; have_in = have_ff;
      rank_in = rank_ff; want_in = want_ff; sq_in = sq_ff;
      rem_in = rem_ff; root_in = root_ff; step_in = step_ff; ins_in = ins_ff;
      ovalid_in = ovalid_ff; olast_in = olast_ff; okind_in = okind_ff;
      odata_in = odata_ff;
      wr_en = 1'b0;
      req_tready = 1'b0;
      skip = 1'b0;
      w = 5'd0;
      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_tready = !ovalid_ff;
            if (req_tvalid && req_tready) begin
               if (req_op == OP_INSERT) begin
                  if (32'(fill_ff) >= CAPACITY) begin
                     okind_in = KIND_FULL;
                     odata_in = pack('0, '0, '0, '0, '0, bminlo_ff,
                                     bminla_ff, bmaxlo_ff, bmaxla_ff, 5'(fill_ff));
                  end else begin
                     wr_en = 1'b1;
                     fill_in = fill_ff + 1'b1;
                     if (fill_ff == '0) begin
                        bminlo_in = req_lon; bmaxlo_in = req_lon;
                        bminla_in = req_lat; bmaxla_in = req_lat;
                     end else begin
                        if (req_lon < bminlo_ff) bminlo_in = req_lon;
                        if (req_lon > bmaxlo_ff) bmaxlo_in = req_lon;
                        if (req_lat < bminla_ff) bminla_in = req_lat;
                        if (req_lat > bmaxla_ff) bmaxla_in = req_lat;
                     end
                     ins_in = 1'b1;
                     state_in = ST_OUT;
                  end
                  if (32'(fill_ff) >= CAPACITY) begin
                     ovalid_in = 1'b1; olast_in = 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  okind_in = KIND_EMPTY;
                  odata_in = pack('0, '0, '0, '0, '0, bminlo_ff,
                                  bminla_ff, bmaxlo_ff, bmaxla_ff, 5'(fill_ff));
                  ovalid_in = 1'b1; olast_in = 1'b1;
               end else begin
                  w = (count_ff == 5'd0) ? 5'd1 : (count_ff > 5'd16) ? 5'd16 : count_ff;
                  want_in = (32'(w) < 32'(fill_ff)) ? (RANK_W+1)'(w)
                                                    : (RANK_W+1)'(fill_ff);
                  qlat_in = req_lat; qlon_in = req_lon;
                  rank_in = '0; idx_in = '0; have_in = 1'b0;
                  sq_in = '0; step_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // two multiplier passes per point: latitude then longitude
            if (step_ff == 5'd0) begin
               sq_in = DSQ_W'(prod);
               step_in = 5'd1;
            end else begin
               skip = (rank_ff != '0) && ((cand_d < prev_d_ff) ||
                      ((cand_d == prev_d_ff) && (idx_ff <= prev_i_ff)));
               if (!skip && (!have_ff || cand_d < best_d_ff)) begin
                  have_in = 1'b1; best_d_in = cand_d; best_i_in = idx_ff;
               end
               step_in = 5'd0;
               if (32'(idx_ff) + 1 >= 32'(fill_ff)) begin
                  state_in = ST_SQRT;
                  rem_in = (!skip && (!have_ff || cand_d < best_d_ff)) ? cand_d : best_d_ff;
                  root_in = '0;
                  step_in = 5'd0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               root_in = (root_ff >> 1) + sbit;
            end else begin
               root_in = root_ff >> 1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd25) begin
               state_in = ST_OUT;
               ins_in = 1'b0;
            end
         end
         ST_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
               if (ins_ff) begin
                  olast_in = 1'b1;
                  okind_in = KIND_STORED;
                  odata_in = pack('0, '0, '0, '0, '0, bminlo_ff,
                                  bminla_ff, bmaxlo_ff, bmaxla_ff, 5'(fill_ff));
                  state_in = ST_IDLE;
               end else begin
                  olast_in = (rank_ff + 1'b1 == want_ff);
                  okind_in = KIND_NEIGHBOR;
                  odata_in = pack(oid, mem_lat[best_i_ff],
                                  mem_lon[best_i_ff],
                                  (root_ff > DSQ_W'({DIST_W{1'b1}})) ?
                                     {DIST_W{1'b1}} : DIST_W'(root_ff),
                                  rank_ff[RANK_W-1:0], bminlo_ff, bminla_ff,
                                  bmaxlo_ff, bmaxla_ff, 5'(fill_ff));
                  prev_d_in = best_d_ff; prev_i_in = best_i_ff;
                  rank_in = rank_ff + 1'b1;
                  if (rank_ff + 1'b1 == want_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = '0; have_in = 1'b0; step_in = '0; sq_in = '0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast = olast_ff;
   assign rsp_tuser = okind_ff;
   assign rsp_tdata = odata_ff;
endmodule

// File: design/nps_checker.sv
// Port-level checks for the nearest point search block.
// Depends on nps_pkg; bound to nearest_point_search.
`timescale 1ns / 1ps
module nps_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast,
   input logic [1:0] rsp_tuser,
   input logic [nps_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import nps_pkg::*;
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response dropped while stalled");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_NEIGHBOR |-> rsp_tlast)
      else $error("non-neighbor response without tlast");
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_NEIGHBOR |-> rsp_tdata[93:0] == '0)
      else $error("non-neighbor response carries neighbor fields");
endmodule

bind nearest_point_search nps_checker u_nps_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tlast(rsp_tlast),
   .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata)
);
